FILE: rtl/hae_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hae_pkg: shared types and constants of the text encoder
// Job and record formats passed between front, queue and back, character
// codes and the base-85 reciprocal.
// ----------------------------------------------------------------------------
package hae_pkg;

  // Register index of output_mode within the configuration space
  localparam logic REG_OUTPUT_MODE = 1'b0;

  // Mode values
  localparam logic MODE_HEX = 1'b0;
  localparam logic MODE_B85 = 1'b1;

  // Depth of the job queue between front and back
  localparam int QDEPTH = 4;

  // Character codes
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] B85_OFS  = 8'd33;

  // floor(x / 85) = (x * RECIP_85) >> RECIP_SHIFT for every 32-bit x
  localparam logic [31:0] RECIP_85    = 32'hC0C0C0C1;
  localparam int          RECIP_SHIFT = 38;
  localparam logic [6:0]  BASE_85     = 7'd85;

  typedef enum logic [1:0] {
    KIND_HEX,
    KIND_B85,
    KIND_ERR
  } kind_t;

  // One unit of work from the front: a byte, a complete group or a row-end error
  typedef struct packed {
    kind_t       kind;
    logic [31:0] data;
    logic        nl;
    logic        close;
  } job_t;

  // A job ready to print: hex byte, error close or five base-85 digits, most significant first
  typedef struct packed {
    kind_t           kind;
    logic [7:0]      data;
    logic [4:0][6:0] dig;
    logic            nl;
    logic            close;
  } rec_t;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'b0, n}) : (8'h57 + {4'b0, n});
  endfunction

endpackage

FILE: rtl/hex_ascii85_text_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_ascii85_text_encoder_unit: image bytes to ASCII hex or ASCII85 text
// Input words carry data_byte and last_of_row; output words carry one text
// character with last_char (last one of its byte or group) and row_error.
// Both channels move a word when valid is high and stall is low.
// The user must write output_mode over the APB port only while the block
// is idle; the block does not enforce this. A write also restarts the open
// group and line.
// The output register moves one character per cycle while out_stall is low;
// a hex byte prints as 2 to 5 characters and an ASCII85 group as 5 to 9.
// The base-85 converter can take a new group as it finishes the last one
// and overlaps the printing of the previous group. Bytes that only fill a
// group are taken one per cycle while the queue is not full.
// A 4-deep job queue separates input from output: when the receiver stalls,
// the output word holds and input is taken until the queue fills.
// Reset returns output_mode to hex and clears the group and line state.
// ----------------------------------------------------------------------------
module hex_ascii85_text_encoder_unit import hae_pkg::*; #(
  parameter int LINE_CHARS = 80
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_of_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        last_char,
  output logic        row_error
);

  logic output_mode;
  logic cfg_clear;
  logic q_push, q_pop, q_empty, q_full;
  job_t q_in, q_out;

  assign pready    = 1'b1;
  assign cfg_clear = psel && penable && pwrite && (paddr[2] == REG_OUTPUT_MODE);
  assign prdata    = (paddr[2] == REG_OUTPUT_MODE) ? {31'b0, output_mode} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_mode <= MODE_HEX;
    end else if (cfg_clear) begin
      output_mode <= pwdata[0];
    end
  end

  hae_front #(
    .LINE_CHARS (LINE_CHARS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .mode        (output_mode),
    .cfg_clear   (cfg_clear),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .last_of_row (last_of_row),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (q_in)
  );

  hae_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty),
    .full      (q_full)
  );

  hae_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .last_char (last_char),
    .row_error (row_error)
  );

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("job pushed into a full queue");

  a_pop_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("job popped from an empty queue");

  a_hex_push: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (output_mode == MODE_HEX) && !cfg_clear) |-> q_push)
    else $error("hex byte accepted without a job");

  a_err_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && row_error && !last_char) |=> (out_valid && row_error))
    else $error("error close sequence broken");

endmodule

FILE: rtl/hae_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hae_front: input acceptance and classification
// Tracks the open ASCII85 group and the line fill, and turns each input word
// into a job for the queue (or absorbs it into the group).
// ----------------------------------------------------------------------------
module hae_front import hae_pkg::*; #(
  parameter int LINE_CHARS = 80
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       mode,
  input  logic       cfg_clear,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_of_row,
  input  logic       q_full,
  output logic       q_push,
  output job_t       q_job
);

  localparam logic [6:0] HEX_LIMIT = 7'(LINE_CHARS / 2);
  localparam logic [6:0] B85_LIMIT = 7'(LINE_CHARS / 5);

  logic [23:0] group_buffer, group_buffer_next;
  logic [1:0]  group_fill, group_fill_next;
  logic [6:0]  line_count, line_count_next;

  logic       accept;
  logic [6:0] cnt_inc;
  logic       line_end;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign cnt_inc  = line_count + 7'd1;

  always_comb begin
    group_buffer_next = group_buffer;
    group_fill_next   = group_fill;
    line_count_next   = line_count;
    q_push            = 1'b0;
    q_job.kind        = KIND_HEX;
    q_job.data        = {24'b0, data_byte};
    q_job.nl          = 1'b0;
    q_job.close       = last_of_row;
    line_end          = last_of_row ||
                        (cnt_inc >= ((mode == MODE_HEX) ? HEX_LIMIT : B85_LIMIT));
    if (cfg_clear) begin
      group_buffer_next = '0;
      group_fill_next   = '0;
      line_count_next   = '0;
    end else if (accept) begin
      if (mode == MODE_HEX) begin
        q_push          = 1'b1;
        q_job.nl        = line_end;
        line_count_next = line_end ? 7'd0 : cnt_inc;
      end else if (group_fill == 2'd3) begin
        q_push            = 1'b1;
        q_job.kind        = KIND_B85;
        q_job.data        = {group_buffer, data_byte};
        q_job.nl          = line_end;
        group_buffer_next = '0;
        group_fill_next   = '0;
        line_count_next   = line_end ? 7'd0 : cnt_inc;
      end else if (last_of_row) begin
        // partial group at row end: drop it and close the line with an error
        q_push            = 1'b1;
        q_job.kind        = KIND_ERR;
        q_job.nl          = 1'b1;
        group_buffer_next = '0;
        group_fill_next   = '0;
        line_count_next   = '0;
      end else begin
        group_buffer_next = {group_buffer[15:0], data_byte};
        group_fill_next   = group_fill + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_buffer <= '0;
      group_fill   <= '0;
      line_count   <= '0;
    end else begin
      group_buffer <= group_buffer_next;
      group_fill   <= group_fill_next;
      line_count   <= line_count_next;
    end
  end

endmodule

FILE: rtl/hae_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hae_queue: short job queue between front and back
// Register-based FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module hae_queue import hae_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  input  logic pop,
  output job_t pop_data,
  output logic empty,
  output logic full
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  job_t             slots [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty    = (count == '0);
  assign full     = (count == CNT_W'(QDEPTH));
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/hae_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hae_back: base-85 conversion and character emission
// A converter pulls jobs and produces print records, one base-85 digit per
// cycle (the last waits for a free record slot); an emitter walks each record
// out through the output register, one character per cycle while not stalled.
// ----------------------------------------------------------------------------
module hae_back import hae_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  job_t       q_data,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       last_char,
  output logic       row_error
);

  // converter
  logic            busy;
  logic [2:0]      step;
  logic [31:0]     rprev;
  logic [31:0]     prodq;
  logic [4:0][6:0] dig;
  logic            conv_nl;
  logic            conv_close;

  // record slot between converter and emitter
  logic rec_valid;
  rec_t rec;

  // emitter
  logic       w_valid;
  rec_t       w;
  logic [3:0] pos;
  logic [3:0] w_len;
  logic [7:0] ch;

  logic        is_b85, finish, start, rec_free, rec_take;
  logic        adv, w_done, load;
  logic [31:0] mult_in;
  logic [63:0] product;
  logic [31:0] mq;
  logic [6:0]  q85;
  logic [6:0]  digit;

  assign is_b85 = (q_data.kind == KIND_B85);

  // quotient by 85 through the reciprocal, remainder from the low bits only
  assign q85     = prodq[6:0] * BASE_85;
  assign digit   = rprev[6:0] - q85;
  assign mult_in = start ? q_data.data : prodq;
  assign product = {32'b0, mult_in} * {32'b0, RECIP_85};
  assign mq      = {6'b0, product[63:RECIP_SHIFT]};

  assign rec_free = !rec_valid || rec_take;
  assign finish   = busy && (step == 3'd4) && rec_free;
  assign q_pop    = !q_empty && ((!busy && (is_b85 || rec_free)) || (finish && is_b85));
  assign start    = q_pop && is_b85;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy && step != 3'd4) begin
      step <= step + 3'd1;
    end else if (finish) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rprev      <= q_data.data;
      prodq      <= mq;
      conv_nl    <= q_data.nl;
      conv_close <= q_data.close;
    end else if (busy && step != 3'd4) begin
      // least significant digit comes out first
      dig[3'd4 - step] <= digit;
      rprev            <= prodq;
      prodq            <= mq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (finish || (q_pop && !is_b85)) begin
      rec_valid <= 1'b1;
    end else if (rec_take) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rec.kind  <= KIND_B85;
      rec.data  <= '0;
      rec.dig   <= {dig[4], dig[3], dig[2], dig[1], digit};
      rec.nl    <= conv_nl;
      rec.close <= conv_close;
    end else if (q_pop && !is_b85) begin
      rec.kind  <= q_data.kind;
      rec.data  <= q_data.data[7:0];
      rec.dig   <= dig;
      rec.nl    <= q_data.nl;
      rec.close <= q_data.close;
    end
  end

  // record length and character at the current position
  always_comb begin
    w_len = 4'd4;
    ch    = CH_NL;
    unique case (w.kind)
      KIND_HEX: begin
        w_len = 4'd2 + {3'b0, w.nl} + {2'b0, w.close, 1'b0};
        unique case (pos)
          4'd0:    ch = hex_char(w.data[7:4]);
          4'd1:    ch = hex_char(w.data[3:0]);
          4'd3:    ch = CH_GT;
          default: ch = CH_NL;
        endcase
      end
      KIND_B85: begin
        w_len = 4'd5 + {3'b0, w.nl} + (w.close ? 4'd3 : 4'd0);
        if (pos < 4'd5) begin
          ch = {1'b0, w.dig[pos[2:0]]} + B85_OFS;
        end else begin
          unique case (pos)
            4'd6:    ch = CH_TILDE;
            4'd7:    ch = CH_GT;
            default: ch = CH_NL;
          endcase
        end
      end
      KIND_ERR: begin
        w_len = 4'd4;
        unique case (pos)
          4'd1:    ch = CH_TILDE;
          4'd2:    ch = CH_GT;
          default: ch = CH_NL;
        endcase
      end
      default: begin
        w_len = 4'd4;
        ch    = CH_NL;
      end
    endcase
  end

  assign adv      = w_valid && (!out_valid || !out_stall);
  assign w_done   = adv && (pos == w_len - 4'd1);
  assign load     = rec_valid && (!w_valid || w_done);
  assign rec_take = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
      pos     <= '0;
    end else if (load) begin
      w_valid <= 1'b1;
      pos     <= '0;
    end else if (w_done) begin
      w_valid <= 1'b0;
    end else if (adv) begin
      pos <= pos + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      w <= rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_char  <= ch;
      last_char <= (pos == w_len - 4'd1);
      row_error <= (w.kind == KIND_ERR);
    end
  end

endmodule
